### hdl/clbch_pkg.sv
// ----------------------------------------------------------------------------
// clbch_pkg: shared constants and helpers
// Bucket width, hash constants and the time33 step used by the pipeline.
// ----------------------------------------------------------------------------
package clbch_pkg;

	localparam int DEF_COUNT_BITS = 32;
	localparam int BKT_W = 6;          // full bucket value, up to 63
	localparam int OUT_BKT_W = 5;
	localparam int HASH_W = 31;
	localparam logic [31:0] TIME33_SEED = 32'd5381;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

	function automatic logic [31:0] t33(input logic [31:0] h, input logic [7:0] c);
		t33 = (h << 5) + h + {24'd0, c};
	endfunction

	// hash the decimal text of a bucket (0..63, one or two digits)
	function automatic logic [31:0] t33_dec(input logic [31:0] h, input logic [BKT_W-1:0] v);
		logic [3:0] tens;
		logic [3:0] ones;
		logic [31:0] r;
		tens = 4'd0;
		if (v >= 6'd60) tens = 4'd6;
		else if (v >= 6'd50) tens = 4'd5;
		else if (v >= 6'd40) tens = 4'd4;
		else if (v >= 6'd30) tens = 4'd3;
		else if (v >= 6'd20) tens = 4'd2;
		else if (v >= 6'd10) tens = 4'd1;
		ones = 4'(v - (6'(tens) * 6'd10));
		r = h;
		if (tens != 4'd0) r = t33(r, CHAR_ZERO + {4'd0, tens});
		t33_dec = t33(r, CHAR_ZERO + {4'd0, ones});
	endfunction

endpackage

### hdl/clbch_ratio.sv
// ----------------------------------------------------------------------------
// clbch_ratio: registered ratio bucket
// Floor-log2 of a/b by leading-one compare; one register stage.
// ----------------------------------------------------------------------------
module clbch_ratio #(
	parameter int COUNT_BITS = clbch_pkg::DEF_COUNT_BITS
) (
	input  logic                            clk,
	input  logic [COUNT_BITS-1:0]           a,
	input  logic [COUNT_BITS-1:0]           b,
	input  logic [clbch_pkg::BKT_W-1:0]     la,   // floor log2 a (0 for 0)
	input  logic [clbch_pkg::BKT_W-1:0]     lb,
	input  logic [clbch_pkg::BKT_W-1:0]     abkt, // count bucket of a
	output logic [clbch_pkg::BKT_W-1:0]     rbkt
);
	import clbch_pkg::*;

	// floor(log2(floor(a/b))) is d or d-1 with d = la-lb; pick by (b<<d) <= a
	logic [BKT_W-1:0]        d;
	logic [2*COUNT_BITS-1:0] bsh;
	logic                    fits;
	logic [BKT_W-1:0]        r;

	always_comb begin
		d = la - lb;
		bsh = {{COUNT_BITS{1'b0}}, b} << d;
		fits = bsh <= {{COUNT_BITS{1'b0}}, a};
		if (b == '0) r = abkt;
		else if (a == '0) r = '0;
		else if (a < b) r = BKT_W'(1);
		else begin
			r = fits ? d : d - BKT_W'(1);
			if (r == '0) r = BKT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		rbkt <= r;
	end
endmodule

### hdl/count_log_bucket_cross_hash_unit.sv
// ----------------------------------------------------------------------------
// count_log_bucket_cross_hash_unit: count buckets, ratio buckets, cross hashes
// Four-stage pipeline from four counts to six buckets and three hashes.
// ----------------------------------------------------------------------------
// A start is registered through v_s1, v_s2 and v_s3 into done; the output
// registers load on the same edge as done.
// Throughput: one word per cycle; busy is always low, no stall path.
// Stages: s1 install select + leading-one search, s2 ratio compare,
// s3 first hash half (x and underscore), s4 second hash half.
// Reset clears the valid bits only; payload registers are not reset.
module count_log_bucket_cross_hash_unit #(
	parameter int COUNT_BITS = clbch_pkg::DEF_COUNT_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [31:0]                        imp_count,
	input  logic [31:0]                        click_count,
	input  logic [31:0]                        install_count,
	input  logic [31:0]                        fallback_install_count,
	output logic                               done,
	output logic [clbch_pkg::OUT_BKT_W-1:0]    imp_bucket,
	output logic [clbch_pkg::OUT_BKT_W-1:0]    click_bucket,
	output logic [clbch_pkg::OUT_BKT_W-1:0]    install_bucket,
	output logic [clbch_pkg::OUT_BKT_W-1:0]    imp_per_click_bucket,
	output logic [clbch_pkg::OUT_BKT_W-1:0]    imp_per_install_bucket,
	output logic [clbch_pkg::OUT_BKT_W-1:0]    click_per_install_bucket,
	output logic [clbch_pkg::HASH_W-1:0]       imp_cross_hash,
	output logic [clbch_pkg::HASH_W-1:0]       imp_install_cross_hash,
	output logic [clbch_pkg::HASH_W-1:0]       click_install_cross_hash
);
	import clbch_pkg::*;

	localparam int CB = COUNT_BITS;
	localparam int IN_W = 32;

	// no stall path: a word may enter every cycle
	assign busy = 1'b0;

	// mask / extend an input to COUNT_BITS (upper bits are zero when wider)
	function automatic logic [CB-1:0] fit(input logic [IN_W-1:0] x);
		logic [CB+IN_W-1:0] e;
		e = {{CB{1'b0}}, x};
		fit = e[CB-1:0];
	endfunction

	function automatic logic [BKT_W-1:0] flog2(input logic [CB-1:0] x);
		logic [BKT_W-1:0] r;
		r = '0;
		for (int i = 0; i < CB; i++)
			if (x[i]) r = BKT_W'(i);
		flog2 = r;
	endfunction

	function automatic logic [BKT_W-1:0] cbkt(input logic [CB-1:0] x, input logic [BKT_W-1:0] l);
		if (x == '0) cbkt = '0;
		else if (l == '0) cbkt = BKT_W'(1);
		else cbkt = l;
	endfunction

	// ---- stage 1: install select, leading-one positions ----
	logic          v_s1;
	logic [CB-1:0] imp_s1, clk_s1, ins_s1;
	logic [BKT_W-1:0] li_s1, lc_s1, ln_s1;
	logic [CB-1:0] imp_m, clk_m, ins_m;

	always_comb begin
		imp_m = fit(imp_count);
		clk_m = fit(click_count);
		ins_m = fit(install_count);
		if (ins_m == '0) ins_m = fit(fallback_install_count);
	end

	always_ff @(posedge clk) begin
		imp_s1 <= imp_m;
		clk_s1 <= clk_m;
		ins_s1 <= ins_m;
		li_s1 <= flog2(imp_m);
		lc_s1 <= flog2(clk_m);
		ln_s1 <= flog2(ins_m);
	end

	// ---- stage 2: count buckets and ratio buckets ----
	logic             v_s2;
	logic [BKT_W-1:0] bi_s2, bc_s2, bn_s2, ric_s2, rii_s2, rci_s2;
	logic [BKT_W-1:0] bi_c, bc_c, bn_c;

	assign bi_c = cbkt(imp_s1, li_s1);
	assign bc_c = cbkt(clk_s1, lc_s1);
	assign bn_c = cbkt(ins_s1, ln_s1);

	always_ff @(posedge clk) begin
		bi_s2 <= bi_c;
		bc_s2 <= bc_c;
		bn_s2 <= bn_c;
	end

	clbch_ratio #(.COUNT_BITS(CB)) u_ric (.clk(clk), .a(imp_s1), .b(clk_s1),
		.la(li_s1), .lb(lc_s1), .abkt(bi_c), .rbkt(ric_s2));
	clbch_ratio #(.COUNT_BITS(CB)) u_rii (.clk(clk), .a(imp_s1), .b(ins_s1),
		.la(li_s1), .lb(ln_s1), .abkt(bi_c), .rbkt(rii_s2));
	clbch_ratio #(.COUNT_BITS(CB)) u_rci (.clk(clk), .a(clk_s1), .b(ins_s1),
		.la(lc_s1), .lb(ln_s1), .abkt(bc_c), .rbkt(rci_s2));

	// ---- stage 3: hash prefix "x_" ----
	logic             v_s3;
	logic [BKT_W-1:0] bi_s3, bc_s3, bn_s3, ric_s3, rii_s3, rci_s3;
	logic [31:0]      hi_s3, hc_s3;

	always_ff @(posedge clk) begin
		bi_s3 <= bi_s2;
		bc_s3 <= bc_s2;
		bn_s3 <= bn_s2;
		ric_s3 <= ric_s2;
		rii_s3 <= rii_s2;
		rci_s3 <= rci_s2;
		hi_s3 <= t33(t33_dec(TIME33_SEED, bi_s2), CHAR_UNDERSCORE);
		hc_s3 <= t33(t33_dec(TIME33_SEED, bc_s2), CHAR_UNDERSCORE);
	end

	// ---- stage 4: hash suffix y, output register ----
	logic [31:0] h1, h2, h3;
	assign h1 = t33_dec(hi_s3, ric_s3);
	assign h2 = t33_dec(hi_s3, rii_s3);
	assign h3 = t33_dec(hc_s3, rci_s3);

	always_ff @(posedge clk) begin
		imp_bucket <= bi_s3[OUT_BKT_W-1:0];
		click_bucket <= bc_s3[OUT_BKT_W-1:0];
		install_bucket <= bn_s3[OUT_BKT_W-1:0];
		imp_per_click_bucket <= ric_s3[OUT_BKT_W-1:0];
		imp_per_install_bucket <= rii_s3[OUT_BKT_W-1:0];
		click_per_install_bucket <= rci_s3[OUT_BKT_W-1:0];
		imp_cross_hash <= h1[HASH_W-1:0];
		imp_install_cross_hash <= h2[HASH_W-1:0];
		click_install_cross_hash <= h3[HASH_W-1:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			done <= v_s3;
		end
	end

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done) else $error("word lost in pipeline");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s3)) else $error("done without a stage 3 word");
	a_ratio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && bi_s2 == '0 |-> ric_s2 == '0 && rii_s2 == '0)
		else $error("zero numerator gave nonzero ratio");
`endif
endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for count_log_bucket_cross_hash_unit
// Drives count words on the count inputs with start, predicts buckets and time33
// cross hashes for each accepted word and checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import clbch_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;

	// one input word
	typedef struct packed {
		logic [31:0] imp;
		logic [31:0] clk_cnt;
		logic [31:0] inst;
		logic [31:0] fb;
	} counts_t;

	// one result word
	typedef struct packed {
		logic [4:0]  b_imp;
		logic [4:0]  b_click;
		logic [4:0]  b_inst;
		logic [4:0]  r_ic;
		logic [4:0]  r_ii;
		logic [4:0]  r_ci;
		logic [30:0] h_ic;
		logic [30:0] h_ii;
		logic [30:0] h_ci;
	} features_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] imp_count = '0;
	logic [31:0] click_count = '0;
	logic [31:0] install_count = '0;
	logic [31:0] fallback_install_count = '0;
	logic done;
	logic [4:0] imp_bucket, click_bucket, install_bucket;
	logic [4:0] imp_per_click_bucket, imp_per_install_bucket, click_per_install_bucket;
	logic [30:0] imp_cross_hash, imp_install_cross_hash, click_install_cross_hash;

	counts_t   pending_words[$];
	features_t expected_features[$];
	int        idle_pct = 0;
	int        errors = 0;
	int        words_sent = 0;
	int        words_checked = 0;
	int        cycles = 0;

	count_log_bucket_cross_hash_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.imp_count(imp_count), .click_count(click_count),
		.install_count(install_count), .fallback_install_count(fallback_install_count),
		.done(done), .imp_bucket(imp_bucket), .click_bucket(click_bucket),
		.install_bucket(install_bucket), .imp_per_click_bucket(imp_per_click_bucket),
		.imp_per_install_bucket(imp_per_install_bucket),
		.click_per_install_bucket(click_per_install_bucket),
		.imp_cross_hash(imp_cross_hash), .imp_install_cross_hash(imp_install_cross_hash),
		.click_install_cross_hash(click_install_cross_hash)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// floor log2 with zero -> 0 and one -> 1
	function automatic int log_bucket(input longint unsigned v);
		int n;
		n = 0;
		if (v == 0) return 0;
		if (v == 1) return 1;
		while (v > 1) begin
			v = v >> 1;
			n++;
		end
		return n;
	endfunction

	function automatic int ratio_bucket_of(input longint unsigned a, input longint unsigned b);
		longint unsigned q;
		if (b == 0) return log_bucket(a);
		if (a == 0) return 0;
		q = a / b;
		if (q < 2) return 1;
		return log_bucket(q);
	endfunction

	// time33 over the decimal text "x_y"
	function automatic logic [30:0] pair_hash(input int x, input int y);
		logic [31:0] h;
		string s;
		s = $sformatf("%0d_%0d", x, y);
		h = 32'd5381;
		for (int i = 0; i < s.len(); i++)
			h = h * 32'd33 + {24'd0, s[i]};
		return h[30:0];
	endfunction

	function automatic features_t predict_features(input counts_t w);
		features_t f;
		longint unsigned inst;
		int bi, bc, bn, ric, rii, rci;
		inst = (w.inst == 0) ? w.fb : w.inst;
		bi = log_bucket(w.imp);
		bc = log_bucket(w.clk_cnt);
		bn = log_bucket(inst);
		ric = ratio_bucket_of(w.imp, w.clk_cnt);
		rii = ratio_bucket_of(w.imp, inst);
		rci = ratio_bucket_of(w.clk_cnt, inst);
		f.b_imp = bi[4:0];
		f.b_click = bc[4:0];
		f.b_inst = bn[4:0];
		f.r_ic = ric[4:0];
		f.r_ii = rii[4:0];
		f.r_ci = rci[4:0];
		f.h_ic = pair_hash(bi, ric);
		f.h_ii = pair_hash(bi, rii);
		f.h_ci = pair_hash(bc, rci);
		return f;
	endfunction

	// random count with a random magnitude so every bucket gets hit
	function automatic logic [31:0] rand_count();
		int sh;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return $urandom_range(2, 3);
			3: return 32'hFFFF_FFFF;
			default: begin
				sh = $urandom_range(0, 31);
				return $urandom() >> sh;
			end
		endcase
	endfunction

	task automatic queue_word(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		pending_words.push_back({a, b, c, d});
	endtask

	// driver: start held while words remain, dropped at random for idling
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_features.push_back(predict_features(
					{imp_count, click_count, install_count, fallback_install_count}));
				words_sent++;
			end
			if ((!start || !busy) && pending_words.size() != 0
					&& $urandom_range(0, 99) >= idle_pct) begin
				counts_t w;
				w = pending_words.pop_front();
				start <= 1'b1;
				imp_count <= w.imp;
				click_count <= w.clk_cnt;
				install_count <= w.inst;
				fallback_install_count <= w.fb;
			end else if (!start || !busy) begin
				start <= 1'b0;
				imp_count <= $urandom();
				click_count <= $urandom();
			end
		end
	end

	// monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) begin
			if (expected_features.size() == 0) begin
				$display("%0t: result with none expected: actual imp_bucket=%0d", $time,
					imp_bucket);
				errors++;
			end else begin
				features_t e, a;
				e = expected_features.pop_front();
				a = {imp_bucket, click_bucket, install_bucket, imp_per_click_bucket,
					imp_per_install_bucket, click_per_install_bucket,
					imp_cross_hash, imp_install_cross_hash, click_install_cross_hash};
				if (a !== e) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, a);
					errors++;
				end
				words_checked++;
			end
		end
	end

	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end

	initial begin
		int phase_pct[4];
		phase_pct = '{0, 88, 0, 17};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, fallback selection, zero divisors, ratio below two
		queue_word(0, 0, 0, 0);
		queue_word(1, 1, 1, 1);
		queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(32'hFFFF_FFFF, 1, 0, 1);
		queue_word(32'hFFFF_FFFF, 0, 0, 0);
		queue_word(0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
		queue_word(100, 0, 0, 7);
		queue_word(100, 60, 0, 0);
		queue_word(3, 2, 5, 9);
		queue_word(4, 2, 2, 3);
		queue_word(1023, 1, 1, 0);
		queue_word(32'h8000_0000, 32'h4000_0000, 32'h0000_0001, 32'h0);
		queue_word(5, 7, 0, 3);
		queue_word(2, 1, 32'hFFFF_FFFE, 5);
		queue_word(32'h0001_0000, 32'h0000_0400, 32'h0000_0020, 32'h0);
		queue_word(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			for (int i = 0; i < 160; i++)
				queue_word(rand_count(), rand_count(),
					($urandom_range(0, 3) == 0) ? 32'd0 : rand_count(), rand_count());
			wait (pending_words.size() == 0);
			@(posedge clk);
		end

		wait (pending_words.size() == 0 && !start);
		while (expected_features.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d count words under four idling phases, checked %0d results.",
			words_sent, words_checked);
		$display("Mismatches: %0d", errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### count_log_bucket_cross_hash_unit.f
hdl/clbch_pkg.sv
hdl/clbch_ratio.sv
hdl/count_log_bucket_cross_hash_unit.sv
bench/tb.sv
